// ===== hdl/shtp_pkg.sv =====
// Shared types and constants for the sensor-hub transport packet reassembler.
`default_nettype none
package shtp_pkg;

  localparam int HEADER_BYTES      = 4;
  localparam int CHUNK_PAYLOAD_DEF = 28;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int CAP_W             = 15;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 15'd512;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_ERROR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_FIN  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_INVALID = 2'd2,
    ST_BUS_ERR = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_CHUNK  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_READ = 2'd1,
    TAIL_FIN  = 2'd2
  } tail_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic       int_level;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       out_kind;
    logic [5:0]       read_len;
    logic [7:0]       out_byte;
    logic [CAP_W-1:0] stored_len;
    logic [1:0]       status;
    logic             last;
  } out_item_t;

  // One accepted word's worth of results: up to four packet bytes, then
  // an optional read request or finished status.
  typedef struct packed {
    logic [2:0]                    nbytes;
    logic [HEADER_BYTES-1:0][7:0]  bytes;
    tail_e                         tail;
    logic [5:0]                    read_len;
    logic [CAP_W-1:0]              stored_len;
    logic [1:0]                    status;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/shtp_front.sv =====
// Front end: accepts input words, runs the packet state and emits commands.
`default_nettype none
module shtp_front import shtp_pkg::*; #(
  parameter int CHUNK_PAYLOAD_MAX = CHUNK_PAYLOAD_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire in_item_t         item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  localparam int RI_W = $clog2(CHUNK_PAYLOAD_MAX + HEADER_BYTES + 1);
  localparam int CP_W = $clog2(CHUNK_PAYLOAD_MAX + 1);

  phase_e           phase_q, phase_d;
  logic [RI_W-1:0]  ri_q, ri_d;
  logic [CP_W-1:0]  cp_q, cp_d;
  logic [CAP_W-1:0] pl_q, pl_d;
  logic [CAP_W-1:0] stored_q, stored_d;
  logic [CAP_W-1:0] capacity_q;
  logic [7:0]       hdr_q [HEADER_BYTES];

  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] len;
  logic [CAP_W-1:0] new_pl;
  logic             pl_done;
  logic [CP_W-1:0]  chunk;
  logic [RI_W-1:0]  ri_next;
  logic             hdr_we;
  cmd_t             cmd;

  assign cap = (capacity_q < CAP_W'(HEADER_BYTES)) ? CAP_W'(HEADER_BYTES) : capacity_q;
  assign len = {hdr_q[1][6:0], hdr_q[0]};
  assign ri_next = ri_q + RI_W'(1);
  assign chunk = (new_pl > CAP_W'(CHUNK_PAYLOAD_MAX)) ? CP_W'(CHUNK_PAYLOAD_MAX)
                                                      : CP_W'(new_pl);

  always_comb begin
    phase_d  = phase_q;
    ri_d     = ri_q;
    cp_d     = cp_q;
    pl_d     = pl_q;
    stored_d = stored_q;
    hdr_we   = 1'b0;
    new_pl   = '0;
    pl_done  = 1'b0;
    cmd      = '0;
    cmd.tail = TAIL_NONE;
    if (accept_i) begin
      case (item_i.req_type)
        REQ_START: begin
          stored_d = '0;
          pl_d     = '0;
          cp_d     = '0;
          ri_d     = '0;
          if (item_i.int_level) begin
            phase_d    = PH_IDLE;
            cmd.tail   = TAIL_FIN;
            cmd.status = ST_NONE;
          end else begin
            phase_d      = PH_HEADER;
            cmd.tail     = TAIL_READ;
            cmd.read_len = 6'(HEADER_BYTES);
          end
        end
        REQ_ERROR: begin
          if (phase_q != PH_IDLE) begin
            phase_d        = PH_IDLE;
            cmd.tail       = TAIL_FIN;
            cmd.stored_len = stored_q;
            cmd.status     = ST_BUS_ERR;
          end
        end
        REQ_BYTE: begin
          if (phase_q == PH_HEADER) begin
            ri_d = ri_next;
            if (ri_q == RI_W'(HEADER_BYTES - 1)) begin
              if (len == '0) begin
                phase_d    = PH_IDLE;
                cmd.tail   = TAIL_FIN;
                cmd.status = ST_NONE;
              end else if (len < CAP_W'(HEADER_BYTES)) begin
                phase_d    = PH_IDLE;
                cmd.tail   = TAIL_FIN;
                cmd.status = ST_INVALID;
              end else begin
                cmd.nbytes   = 3'(HEADER_BYTES);
                cmd.bytes[0] = hdr_q[0];
                cmd.bytes[1] = hdr_q[1];
                cmd.bytes[2] = hdr_q[2];
                cmd.bytes[3] = item_i.rx_byte;
                stored_d     = CAP_W'(HEADER_BYTES);
                new_pl       = len - CAP_W'(HEADER_BYTES);
                pl_done      = 1'b1;
              end
            end else begin
              hdr_we = 1'b1;
            end
          end else if (phase_q == PH_CHUNK) begin
            ri_d = ri_next;
            if (ri_q >= RI_W'(HEADER_BYTES) && stored_q < cap) begin
              cmd.nbytes   = 3'd1;
              cmd.bytes[0] = item_i.rx_byte;
              stored_d     = stored_q + CAP_W'(1);
            end
            if (ri_next >= RI_W'(32'(cp_q) + HEADER_BYTES)) begin
              new_pl  = (pl_q >= CAP_W'(cp_q)) ? pl_q - CAP_W'(cp_q) : '0;
              pl_done = 1'b1;
            end
          end
        end
        default: ;
      endcase
      // end of header or chunk: finish the packet or ask for the next chunk
      if (pl_done) begin
        pl_d = new_pl;
        if (new_pl == '0) begin
          phase_d        = PH_IDLE;
          cmd.tail       = TAIL_FIN;
          cmd.stored_len = stored_d;
          cmd.status     = ST_OK;
        end else begin
          phase_d      = PH_CHUNK;
          cp_d         = chunk;
          ri_d         = '0;
          cmd.tail     = TAIL_READ;
          cmd.read_len = 6'(32'(chunk) + HEADER_BYTES);
        end
      end
    end
  end

  assign push_o = accept_i && (cmd.nbytes != '0 || cmd.tail != TAIL_NONE);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      ri_q       <= '0;
      cp_q       <= '0;
      pl_q       <= '0;
      stored_q   <= '0;
      capacity_q <= CAPACITY_RESET;
    end else begin
      phase_q  <= phase_d;
      ri_q     <= ri_d;
      cp_q     <= cp_d;
      pl_q     <= pl_d;
      stored_q <= stored_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[ri_q[1:0]] <= item_i.rx_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_stored_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CHUNK |-> stored_q <= cap)
    else $error("stored count passed capacity");
  a_chunk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CHUNK |-> ri_q < RI_W'(32'(cp_q) + HEADER_BYTES))
    else $error("chunk read index ran past chunk end");
`endif

endmodule
`default_nettype wire

// ===== hdl/shtp_cmd_queue.sv =====
// Small command queue between front end and output sequencer.
`default_nettype none
module shtp_cmd_queue import shtp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full command queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty command queue");
`endif

endmodule
`default_nettype wire

// ===== hdl/shtp_back.sv =====
// Output sequencer: expands queued commands into result words.
`default_nettype none
module shtp_back import shtp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  out_item_t  out_q, out_d;
  logic       load;
  logic       is_byte;
  logic       last_el;

  assign load    = !empty_i && (!valid_q || !out_stall_i);
  assign is_byte = idx_q < cmd_i.nbytes;
  assign last_el = is_byte ? (idx_q == cmd_i.nbytes - 3'd1 && cmd_i.tail == TAIL_NONE)
                           : 1'b1;
  assign pop_o   = load && last_el;

  always_comb begin
    out_d      = '0;
    out_d.last = last_el;
    if (is_byte) begin
      out_d.out_kind = KIND_BYTE;
      out_d.out_byte = cmd_i.bytes[idx_q[1:0]];
    end else if (cmd_i.tail == TAIL_READ) begin
      out_d.out_kind = KIND_READ;
      out_d.read_len = cmd_i.read_len;
    end else begin
      out_d.out_kind   = KIND_FIN;
      out_d.stored_len = cmd_i.stored_len;
      out_d.status     = cmd_i.status;
    end
    idx_d   = load ? (last_el ? 3'd0 : idx_q + 3'd1) : idx_q;
    valid_d = load || (valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q && out_q.last)
    else $error("command retired without a last word");
  a_idx_reset_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 3'd0)
    else $error("element index not rewound after command");
`endif

endmodule
`default_nettype wire

// ===== hdl/shtp_i2c_packet_reassembler_core.sv =====
// Top level of the sensor-hub transport packet reassembler.
`default_nettype none
// Rebuilds one transport packet from successive bus reads. Input words are
// start attempts, delivered bytes and bus errors; results are read requests,
// stored packet bytes and a finished status, with last set on the final
// result of each input word. The front end takes one input word per cycle
// and turns it into a command in a small queue; the output sequencer sends
// one result word per cycle from the queue head unless the output is stalled.
// Most words make at most two results; the word that completes a header
// makes up to five, which the queue absorbs while further input keeps flowing.
// Input is stalled only when the queue is full. Capacity may be written
// only while no packet is being delivered.
module shtp_i2c_packet_reassembler_core import shtp_pkg::*; #(
  parameter int CHUNK_PAYLOAD_MAX = CHUNK_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i
);

  logic accept;
  logic push;
  logic pop;
  logic empty;
  logic full;
  cmd_t cmd_in;
  cmd_t cmd_head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  shtp_front #(
    .CHUNK_PAYLOAD_MAX(CHUNK_PAYLOAD_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  shtp_cmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .head_o (cmd_head),
    .empty_o(empty),
    .full_o (full)
  );

  shtp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
